@@ design/dltq_pkg.sv @@
// ----------------------------------------------------------------------------
// dltq_pkg: shared types and constants for the delta-list timer queue
// Holds the word layouts of both channels, the action codes, and the command
// and status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int ID_W          = 16;
  localparam int DELTA_W       = 24;
  localparam int COUNT_W       = 5;

  // Action codes of the input word.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [ID_W-1:0]    timer_id;
    logic [DELTA_W-1:0] delay;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
    logic               head_valid;
    logic [ID_W-1:0]    head_id;
    logic [DELTA_W-1:0] head_delta;
    logic               head_expired;
  } out_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_START,
    DP_INS_ADV,
    DP_INS_STOP,
    DP_INS_SHIFT,
    DP_INS_PLACE,
    DP_CAN_ADV,
    DP_CAN_FOUND,
    DP_CAN_SHIFT,
    DP_CAN_END,
    DP_TICK
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic full;         // queue holds DEPTH timers
    logic scan_more;    // scan position is below the count
    logic delta_le;     // entry under the scan has delta <= remaining delay
    logic id_match;     // entry under the scan carries the wanted id
    logic k_gt_pos;     // insert shift has not yet reached the slot
    logic k1_lt_count;  // cancel shift has entries left to pull down
  } sts_t;

endpackage

@@ design/dltq_datapath.sv @@
// ----------------------------------------------------------------------------
// dltq_datapath: entry memory, walk pointers and result register
// Executes one controller operation per cycle on the id/delta memory and
// keeps a copy of entry zero so the head can be reported without a read.
// ----------------------------------------------------------------------------
module dltq_datapath #(
  parameter int DEPTH = dltq_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  dltq_pkg::in_t  in_data,
  input  dltq_pkg::cmd_t cmd,
  output dltq_pkg::sts_t sts,
  output dltq_pkg::out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = dltq_pkg::ID_W + dltq_pkg::DELTA_W;

  typedef struct packed {
    logic [dltq_pkg::ID_W-1:0]    id;
    logic [dltq_pkg::DELTA_W-1:0] delta;
  } entry_t;

  entry_t mem [DEPTH];
  entry_t rd;

  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic [CW-1:0] k;
  logic [dltq_pkg::ID_W-1:0]    id_r;
  logic [dltq_pkg::DELTA_W-1:0] d;
  logic [dltq_pkg::DELTA_W-1:0] succ;
  logic                         ok;
  logic [dltq_pkg::ID_W-1:0]    head_id;
  logic [dltq_pkg::DELTA_W-1:0] head_delta;

  logic [AW-1:0] ra;
  logic [AW-1:0] wa;
  logic          we;
  entry_t        wd;
  logic [dltq_pkg::DELTA_W:0]   sum;
  logic [dltq_pkg::DELTA_W-1:0] sat_sum;
  logic [CW-1:0] pos_inc;
  logic [CW-1:0] k_inc;

  assign pos_inc = CW'(pos + 1'b1);
  assign k_inc   = CW'(k + 1'b1);
  assign sum     = {1'b0, rd.delta} + {1'b0, d};
  assign sat_sum = sum[dltq_pkg::DELTA_W] ? '1 : sum[dltq_pkg::DELTA_W-1:0];

  assign sts.full        = (count == CW'(DEPTH));
  assign sts.scan_more   = (pos < count);
  assign sts.delta_le    = (rd.delta <= d);
  assign sts.id_match    = (rd.id == id_r);
  assign sts.k_gt_pos    = (k > pos);
  assign sts.k1_lt_count = (k_inc < count);

  always_comb begin
    ra = '0;
    wa = '0;
    we = 1'b0;
    wd = entry_t'({EW{1'b0}});
    unique case (cmd.op)
      dltq_pkg::DP_INS_ADV:   ra = pos_inc[AW-1:0];
      dltq_pkg::DP_INS_STOP:  ra = AW'(count - 1'b1);
      dltq_pkg::DP_INS_SHIFT: begin
        // Move entry k-1 up to k; the old occupant of the slot gets the
        // remainder taken off its delta.
        we       = 1'b1;
        wa       = k[AW-1:0];
        wd.id    = rd.id;
        wd.delta = (k == pos_inc) ? succ : rd.delta;
        ra       = AW'(k - CW'(2));
      end
      dltq_pkg::DP_INS_PLACE: begin
        we       = 1'b1;
        wa       = pos[AW-1:0];
        wd.id    = id_r;
        wd.delta = d;
      end
      dltq_pkg::DP_CAN_ADV:   ra = pos_inc[AW-1:0];
      dltq_pkg::DP_CAN_FOUND: ra = pos_inc[AW-1:0];
      dltq_pkg::DP_CAN_SHIFT: begin
        // Pull entry k+1 down to k; the successor of the removed timer
        // absorbs its delta.
        we       = 1'b1;
        wa       = k[AW-1:0];
        wd.id    = rd.id;
        wd.delta = (k == pos) ? sat_sum : rd.delta;
        ra       = AW'(k + CW'(2));
      end
      dltq_pkg::DP_TICK: begin
        if (count != '0 && head_delta != '0) begin
          we       = 1'b1;
          wd.id    = head_id;
          wd.delta = head_delta - 1'b1;
        end
      end
      default: ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cmd.op)
        dltq_pkg::DP_INS_PLACE: count <= CW'(count + 1'b1);
        dltq_pkg::DP_CAN_END:   count <= CW'(count - 1'b1);
        default:                count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      dltq_pkg::DP_START: begin
        id_r <= in_data.timer_id;
        d    <= in_data.delay;
        pos  <= '0;
        ok   <= 1'b0;
      end
      dltq_pkg::DP_INS_ADV: begin
        d   <= d - rd.delta;
        pos <= pos_inc;
      end
      dltq_pkg::DP_INS_STOP: begin
        succ <= rd.delta - d;
        k    <= count;
      end
      dltq_pkg::DP_INS_SHIFT: k   <= CW'(k - 1'b1);
      dltq_pkg::DP_INS_PLACE: ok  <= 1'b1;
      dltq_pkg::DP_CAN_ADV:   pos <= pos_inc;
      dltq_pkg::DP_CAN_FOUND: begin
        d <= rd.delta;
        k <= pos;
      end
      dltq_pkg::DP_CAN_SHIFT: k  <= k_inc;
      dltq_pkg::DP_CAN_END:   ok <= 1'b1;
      dltq_pkg::DP_TICK:      ok <= 1'b1;
      default:                ok <= ok;
    endcase

    if (we && wa == '0) begin
      head_id    <= wd.id;
      head_delta <= wd.delta;
    end

    if (cmd.load_out) begin
      out_data.ok           <= ok;
      out_data.count        <= dltq_pkg::COUNT_W'(count);
      out_data.head_valid   <= (count != '0);
      out_data.head_id      <= (count != '0) ? head_id : '0;
      out_data.head_delta   <= (count != '0) ? head_delta : '0;
      out_data.head_expired <= (count != '0) && (head_delta == '0);
    end
  end

endmodule

@@ design/dltq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dltq_ctrl: sequencing state machine for the timer queue
// Accepts one word at a time, steps the datapath through the scan and shift
// phases of insert and cancel or the tick step, and loads the output register.
// ----------------------------------------------------------------------------
module dltq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     action,
  output logic           out_valid,
  input  logic           out_ready,
  input  dltq_pkg::sts_t sts,
  output dltq_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_SHIFT,
    S_CAN_SCAN,
    S_CAN_SHIFT,
    S_TICK,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next   = state;
    cmd.op       = dltq_pkg::DP_NOP;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = dltq_pkg::DP_START;
          if (action == dltq_pkg::ACT_INSERT) begin
            state_next = sts.full ? S_FIN : S_INS_SCAN;
          end else if (action == dltq_pkg::ACT_CANCEL) begin
            state_next = S_CAN_SCAN;
          end else if (action == dltq_pkg::ACT_TICK) begin
            state_next = S_TICK;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_INS_SCAN: begin
        if (sts.scan_more && sts.delta_le) begin
          cmd.op = dltq_pkg::DP_INS_ADV;
        end else begin
          cmd.op     = dltq_pkg::DP_INS_STOP;
          state_next = S_INS_SHIFT;
        end
      end
      S_INS_SHIFT: begin
        if (sts.k_gt_pos) begin
          cmd.op = dltq_pkg::DP_INS_SHIFT;
        end else begin
          cmd.op     = dltq_pkg::DP_INS_PLACE;
          state_next = S_FIN;
        end
      end
      S_CAN_SCAN: begin
        priority if (!sts.scan_more) begin
          state_next = S_FIN;
        end else if (sts.id_match) begin
          cmd.op     = dltq_pkg::DP_CAN_FOUND;
          state_next = S_CAN_SHIFT;
        end else begin
          cmd.op = dltq_pkg::DP_CAN_ADV;
        end
      end
      S_CAN_SHIFT: begin
        if (sts.k1_lt_count) begin
          cmd.op = dltq_pkg::DP_CAN_SHIFT;
        end else begin
          cmd.op     = dltq_pkg::DP_CAN_END;
          state_next = S_FIN;
        end
      end
      S_TICK: begin
        cmd.op     = dltq_pkg::DP_TICK;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/delta_list_timer_queue.sv @@
// ----------------------------------------------------------------------------
// delta_list_timer_queue: bounded delta-list timer queue, top level
// A refused insert or an unknown action goes straight to the result word.
// Throughput: one word at a time; the walk over the entry memory, one entry
// per cycle through its single read port and single write port, sets the rate.
// Reset: synchronous; the queue comes up empty and the entry memory is left
// as it is, since entries at or above the count never reach a result.
// ----------------------------------------------------------------------------
module delta_list_timer_queue #(
  parameter int DEPTH = dltq_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dltq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dltq_pkg::out_t out_data
);

  // The controller decides the sequence of datapath operations for each
  // accepted word. Insert scans from the head while the entry delta fits in
  // the remaining delay, then shifts the tail up one slot from the back and
  // writes the new timer into the hole. Cancel scans for the first matching
  // id, then pulls the tail down one slot, folding the removed delta into its
  // successor. A tick takes one off a nonzero entry-zero delta when the queue is not empty.
  //
  // The result word sits in an output register. A new input word is taken
  // as soon as the controller is idle, even while the previous result still
  // waits; the final load stalls only if that result has not been taken.

  dltq_pkg::cmd_t cmd;
  dltq_pkg::sts_t sts;

  dltq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (in_data.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dltq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // Only one word is in work at a time: after an acceptance the input side
  // closes until the result has been loaded.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is still in work");

  // A new timer is never placed into a full queue.
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == dltq_pkg::DP_INS_PLACE) |-> !sts.full)
    else $error("insert placed into a full queue");

  // The result register is only loaded when its old word is gone or leaving.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result word overwritten before it was taken");

  // A finished load presents a valid word in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result word not presented");

endmodule
